>>> src/epc_pkg.sv
// Shared types, constants and codes for the Ethernet packet classifier.
// No dependencies; every other file but epc_ifs takes names from here by scope.

package epc_pkg;

    // Packet counter width; counters wrap at this width
    localparam int COUNT_WIDTH = 32;
    localparam int NUM_COUNTERS = 9;
    localparam int POS_W = 7;

    typedef logic [COUNT_WIDTH-1:0] counter_t;
    typedef logic [POS_W-1:0]       pos_t;

    // Beat actions and result kinds
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_READ  = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    // Byte positions within the frame
    localparam pos_t POS_MAX       = 7'd127;
    localparam pos_t ETYPE_HI_IDX  = 7'd12;
    localparam pos_t ETYPE_LO_IDX  = 7'd13;
    localparam pos_t ETH_HDR_LEN   = 7'd14;
    localparam pos_t IP6_HDR_LEN   = 7'd40;
    localparam pos_t IP6_L4_START  = ETH_HDR_LEN + IP6_HDR_LEN;
    localparam pos_t IP4_PROTO_IDX = 7'd23;
    localparam pos_t IP6_NH_IDX    = 7'd20;
    localparam pos_t IP4_PROTO_END = 7'd24;
    localparam pos_t IP6_NH_END    = 7'd21;
    localparam pos_t L4_PORT_BYTES = 7'd4;
    localparam logic [3:0] IHL_MIN = 4'd5;

    // Ethertypes
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    // Network layer kinds
    localparam logic [1:0] NK_NONE = 2'd0;
    localparam logic [1:0] NK_IP4  = 2'd1;
    localparam logic [1:0] NK_IP6  = 2'd2;
    localparam logic [1:0] NK_ARP  = 2'd3;

    // IP protocol numbers
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'h3a;

    // Well-known ports
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_FTP   = 16'd21;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_DNS   = 16'd53;
    localparam logic [15:0] PORT_DHCP  = 16'd68;

    // Packet classes
    localparam logic [3:0] CLS_UNKNOWN = 4'd0;
    localparam logic [3:0] CLS_ARP     = 4'd1;
    localparam logic [3:0] CLS_ICMP    = 4'd2;
    localparam logic [3:0] CLS_ICMPV6  = 4'd3;
    localparam logic [3:0] CLS_HTTP    = 4'd4;
    localparam logic [3:0] CLS_FTP     = 4'd5;
    localparam logic [3:0] CLS_HTTPS   = 4'd6;
    localparam logic [3:0] CLS_TCP     = 4'd7;
    localparam logic [3:0] CLS_DNS     = 4'd8;
    localparam logic [3:0] CLS_DHCP    = 4'd9;
    localparam logic [3:0] CLS_UDP     = 4'd10;

    // Counter indexes
    localparam int CNT_TOTAL  = 0;
    localparam int CNT_IPV4   = 1;
    localparam int CNT_IPV6   = 2;
    localparam int CNT_ARP    = 3;
    localparam int CNT_OTHER  = 4;
    localparam int CNT_ICMP   = 5;
    localparam int CNT_ICMPV6 = 6;
    localparam int CNT_TCP    = 7;
    localparam int CNT_UDP    = 8;

endpackage

>>> src/epc_ifs.sv
// Handshake channels of the Ethernet packet classifier: input beats and results.
// Depends on nothing; widths follow the beat and result field definitions.

interface epc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] counter_select;

    modport source (output valid, action, data_byte, last_byte, counter_select,
                    input ready);
    modport sink   (input valid, action, data_byte, last_byte, counter_select,
                    output ready);
endinterface

interface epc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [3:0]  packet_class;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        truncated;
    logic [31:0] counter_value;

    modport source (output valid, result_kind, packet_class, ether_type, ip_protocol,
                    source_port, dest_port, truncated, counter_value,
                    input ready);
    modport sink   (input valid, result_kind, packet_class, ether_type, ip_protocol,
                    source_port, dest_port, truncated, counter_value,
                    output ready);
endinterface

>>> src/ethernet_packet_classifier_top.sv
// Top level of the Ethernet packet classifier: header parser, class decision,
// packet counters and result register. Depends on epc_pkg and epc_ifs.

// The classifier takes one beat per clock: a frame byte in wire order, or a
// counter read. Each beat is handled in the cycle it is accepted, and its
// result (on the last byte of a frame, or on a read) appears in the output
// register on the next cycle. A beat that produces no result is always
// accepted; a beat that produces a result is accepted as long as the output
// register is empty or being taken in the same cycle, so throughput is one
// beat per cycle when the sink keeps ready high. Counter reads see every frame
// finished before them. Frame bytes beyond index 126 are ignored.

module ethernet_packet_classifier_top (
    input  logic       clk,
    input  logic       rst_n,
    epc_in_if.sink     in_ch,
    epc_out_if.source  out_ch
);

    // Frame parse state
    epc_pkg::pos_t  byte_pos_reg;
    logic [15:0]    frame_type_reg;
    logic [1:0]     net_kind_reg;
    epc_pkg::pos_t  l4_start_reg;
    logic [7:0]     protocol_reg;
    logic [15:0]    src_port_reg;
    logic [15:0]    dst_port_reg;

    epc_pkg::counter_t counter_reg [epc_pkg::NUM_COUNTERS];

    // Output register
    logic        out_valid_reg;
    logic        kind_reg;
    logic [3:0]  class_reg;
    logic [15:0] etype_out_reg;
    logic [7:0]  proto_out_reg;
    logic [15:0] sport_out_reg;
    logic [15:0] dport_out_reg;
    logic        trunc_reg;
    logic [31:0] count_out_reg;

    // Values after taking the current byte
    epc_pkg::pos_t  byte_pos_next;
    logic [15:0]    frame_type_next;
    logic [1:0]     net_kind_next;
    epc_pkg::pos_t  l4_start_next;
    logic [7:0]     protocol_next;
    logic [15:0]    src_port_next;
    logic [15:0]    dst_port_next;

    logic [3:0]     ihl_eff;
    epc_pkg::pos_t  l4_offset;
    logic           in_port_field;

    // Frame result
    logic [3:0]  cls;
    logic [15:0] res_etype;
    logic [7:0]  res_proto;
    logic [15:0] res_sport;
    logic [15:0] res_dport;
    logic        res_trunc;
    logic [epc_pkg::NUM_COUNTERS-1:0] bump;
    logic        is_v4;
    logic        is_tcp;
    logic [31:0] read_value;

    logic accept;
    logic data_beat;
    logic gives_result;
    logic frame_end;

    assign data_beat    = (in_ch.action == epc_pkg::ACT_DATA);
    assign gives_result = !data_beat || in_ch.last_byte;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready || !gives_result;
    assign accept       = in_ch.valid && in_ch.ready;
    assign frame_end    = accept && data_beat && in_ch.last_byte;

    // Take one frame byte into the header state
    always_comb
    begin
        frame_type_next = frame_type_reg;
        net_kind_next   = net_kind_reg;
        l4_start_next   = l4_start_reg;
        protocol_next   = protocol_reg;
        src_port_next   = src_port_reg;
        dst_port_next   = dst_port_reg;

        ihl_eff = (in_ch.data_byte[3:0] < epc_pkg::IHL_MIN) ?
                  epc_pkg::IHL_MIN : in_ch.data_byte[3:0];
        l4_offset = byte_pos_reg - l4_start_reg;
        in_port_field = (net_kind_reg == epc_pkg::NK_IP4 ||
                         net_kind_reg == epc_pkg::NK_IP6) &&
                        (byte_pos_reg >= epc_pkg::ETH_HDR_LEN) &&
                        (l4_start_reg != '0) &&
                        (byte_pos_reg >= l4_start_reg) &&
                        (l4_offset < epc_pkg::L4_PORT_BYTES);

        if (byte_pos_reg == epc_pkg::ETYPE_HI_IDX)
        begin
            frame_type_next = {in_ch.data_byte, 8'h00};
        end
        if (byte_pos_reg == epc_pkg::ETYPE_LO_IDX)
        begin
            frame_type_next = {frame_type_reg[15:8], in_ch.data_byte};
            if (frame_type_next == epc_pkg::ETYPE_IPV4)
            begin
                net_kind_next = epc_pkg::NK_IP4;
            end
            else if (frame_type_next == epc_pkg::ETYPE_IPV6)
            begin
                net_kind_next = epc_pkg::NK_IP6;
                l4_start_next = epc_pkg::IP6_L4_START;
            end
            else if (frame_type_next == epc_pkg::ETYPE_ARP)
            begin
                net_kind_next = epc_pkg::NK_ARP;
            end
            else
            begin
                net_kind_next = epc_pkg::NK_NONE;
            end
        end
        if (net_kind_reg == epc_pkg::NK_IP4 && byte_pos_reg == epc_pkg::ETH_HDR_LEN)
        begin
            l4_start_next = epc_pkg::ETH_HDR_LEN + {1'b0, ihl_eff, 2'b00};
        end
        if ((net_kind_reg == epc_pkg::NK_IP4 && byte_pos_reg == epc_pkg::IP4_PROTO_IDX) ||
            (net_kind_reg == epc_pkg::NK_IP6 && byte_pos_reg == epc_pkg::IP6_NH_IDX))
        begin
            protocol_next = in_ch.data_byte;
        end
        if (in_port_field)
        begin
            case (l4_offset[1:0])
                2'd0:    src_port_next = {in_ch.data_byte, 8'h00};
                2'd1:    src_port_next = {src_port_reg[15:8], in_ch.data_byte};
                2'd2:    dst_port_next = {in_ch.data_byte, 8'h00};
                default: dst_port_next = {dst_port_reg[15:8], in_ch.data_byte};
            endcase
        end

        byte_pos_next = (byte_pos_reg == epc_pkg::POS_MAX) ?
                        byte_pos_reg : byte_pos_reg + 7'd1;
    end

    // Decide the class at frame end and pick counters to bump
    always_comb
    begin
        cls       = epc_pkg::CLS_UNKNOWN;
        res_etype = '0;
        res_proto = '0;
        res_sport = '0;
        res_dport = '0;
        res_trunc = 1'b0;
        bump      = '0;
        is_v4     = (net_kind_next == epc_pkg::NK_IP4);
        is_tcp    = (protocol_next == epc_pkg::PROTO_TCP);

        bump[epc_pkg::CNT_TOTAL] = 1'b1;
        if (byte_pos_next < epc_pkg::ETH_HDR_LEN)
        begin
            res_trunc = 1'b1;
        end
        else
        begin
            res_etype = frame_type_next;
            if (net_kind_next == epc_pkg::NK_ARP)
            begin
                cls = epc_pkg::CLS_ARP;
                bump[epc_pkg::CNT_ARP] = 1'b1;
            end
            else if (net_kind_next == epc_pkg::NK_NONE)
            begin
                bump[epc_pkg::CNT_OTHER] = 1'b1;
            end
            else
            begin
                bump[epc_pkg::CNT_IPV4] = is_v4;
                bump[epc_pkg::CNT_IPV6] = !is_v4;
                if (byte_pos_next < (is_v4 ? epc_pkg::IP4_PROTO_END : epc_pkg::IP6_NH_END))
                begin
                    res_trunc = 1'b1;
                end
                else
                begin
                    res_proto = protocol_next;
                    if (is_v4 && protocol_next == epc_pkg::PROTO_ICMP)
                    begin
                        cls = epc_pkg::CLS_ICMP;
                        bump[epc_pkg::CNT_ICMP] = 1'b1;
                    end
                    else if (!is_v4 && protocol_next == epc_pkg::PROTO_ICMPV6)
                    begin
                        cls = epc_pkg::CLS_ICMPV6;
                        bump[epc_pkg::CNT_ICMPV6] = 1'b1;
                    end
                    else if (is_tcp || protocol_next == epc_pkg::PROTO_UDP)
                    begin
                        bump[epc_pkg::CNT_TCP] = is_tcp;
                        bump[epc_pkg::CNT_UDP] = !is_tcp;
                        if ({1'b0, byte_pos_next} <
                            {1'b0, l4_start_next} + {1'b0, epc_pkg::L4_PORT_BYTES})
                        begin
                            res_trunc = 1'b1;
                            cls = is_tcp ? epc_pkg::CLS_TCP : epc_pkg::CLS_UDP;
                        end
                        else
                        begin
                            res_sport = src_port_next;
                            res_dport = dst_port_next;
                            if (is_tcp)
                            begin
                                if (res_sport == epc_pkg::PORT_HTTP ||
                                    res_dport == epc_pkg::PORT_HTTP)
                                    cls = epc_pkg::CLS_HTTP;
                                else if (res_sport == epc_pkg::PORT_FTP ||
                                         res_dport == epc_pkg::PORT_FTP)
                                    cls = epc_pkg::CLS_FTP;
                                else if (res_sport == epc_pkg::PORT_HTTPS ||
                                         res_dport == epc_pkg::PORT_HTTPS)
                                    cls = epc_pkg::CLS_HTTPS;
                                else
                                    cls = epc_pkg::CLS_TCP;
                            end
                            else
                            begin
                                if (res_sport == epc_pkg::PORT_DNS ||
                                    res_dport == epc_pkg::PORT_DNS)
                                    cls = epc_pkg::CLS_DNS;
                                else if (res_sport == epc_pkg::PORT_DHCP ||
                                         res_dport == epc_pkg::PORT_DHCP)
                                    cls = epc_pkg::CLS_DHCP;
                                else
                                    cls = epc_pkg::CLS_UDP;
                            end
                        end
                    end
                end
            end
        end
    end

    // Select the counter for a read; out-of-range selects read as zero
    always_comb
    begin
        read_value = '0;
        if (in_ch.counter_select < 4'(epc_pkg::NUM_COUNTERS))
        begin
            read_value = 32'(counter_reg[in_ch.counter_select]);
        end
    end

    // Advance the header state on data beats; drop it at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            frame_type_reg <= '0;
            net_kind_reg   <= epc_pkg::NK_NONE;
            l4_start_reg   <= '0;
            protocol_reg   <= '0;
            src_port_reg   <= '0;
            dst_port_reg   <= '0;
        end
        else if (accept && data_beat)
        begin
            if (in_ch.last_byte)
            begin
                byte_pos_reg   <= '0;
                frame_type_reg <= '0;
                net_kind_reg   <= epc_pkg::NK_NONE;
                l4_start_reg   <= '0;
                protocol_reg   <= '0;
                src_port_reg   <= '0;
                dst_port_reg   <= '0;
            end
            else
            begin
                byte_pos_reg   <= byte_pos_next;
                frame_type_reg <= frame_type_next;
                net_kind_reg   <= net_kind_next;
                l4_start_reg   <= l4_start_next;
                protocol_reg   <= protocol_next;
                src_port_reg   <= src_port_next;
                dst_port_reg   <= dst_port_next;
            end
        end
    end

    // Bump the packet counters at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < epc_pkg::NUM_COUNTERS; i++)
            begin
                counter_reg[i] <= '0;
            end
        end
        else if (frame_end)
        begin
            for (int i = 0; i < epc_pkg::NUM_COUNTERS; i++)
            begin
                if (bump[i])
                begin
                    counter_reg[i] <= counter_reg[i] + epc_pkg::counter_t'(1);
                end
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && gives_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept && gives_result)
        begin
            if (data_beat)
            begin
                kind_reg      <= epc_pkg::KIND_FRAME;
                class_reg     <= cls;
                etype_out_reg <= res_etype;
                proto_out_reg <= res_proto;
                sport_out_reg <= res_sport;
                dport_out_reg <= res_dport;
                trunc_reg     <= res_trunc;
                count_out_reg <= '0;
            end
            else
            begin
                kind_reg      <= epc_pkg::KIND_COUNT;
                class_reg     <= epc_pkg::CLS_UNKNOWN;
                etype_out_reg <= '0;
                proto_out_reg <= '0;
                sport_out_reg <= '0;
                dport_out_reg <= '0;
                trunc_reg     <= 1'b0;
                count_out_reg <= read_value;
            end
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.result_kind   = kind_reg;
    assign out_ch.packet_class  = class_reg;
    assign out_ch.ether_type    = etype_out_reg;
    assign out_ch.ip_protocol   = proto_out_reg;
    assign out_ch.source_port   = sport_out_reg;
    assign out_ch.dest_port     = dport_out_reg;
    assign out_ch.truncated     = trunc_reg;
    assign out_ch.counter_value = count_out_reg;

    // A finished frame always leaves a frame result in the output register
    a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (out_ch.valid && out_ch.result_kind == epc_pkg::KIND_FRAME))
        else $error("frame end did not produce a frame result");

    // A network kind is only known once the ethertype is complete
    a_kind_after_etype: assert property (@(posedge clk) disable iff (!rst_n)
        (net_kind_reg != epc_pkg::NK_NONE) |-> (byte_pos_reg >= epc_pkg::ETH_HDR_LEN))
        else $error("network kind set before ethertype");

    // A layer-4 start is only set from the ethertype or IHL byte onward
    a_l4_after_etype: assert property (@(posedge clk) disable iff (!rst_n)
        (l4_start_reg != '0) |-> (byte_pos_reg >= epc_pkg::ETH_HDR_LEN))
        else $error("layer-4 start set too early");

    // Byte position saturates on long frames
    a_pos_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && data_beat && !in_ch.last_byte && byte_pos_reg == epc_pkg::POS_MAX)
        |=> (byte_pos_reg == epc_pkg::POS_MAX))
        else $error("byte position wrapped");

endmodule

>>> verif/epc_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the Ethernet packet classifier: watches both channels, predicts every result.
// Depends on epc_pkg for codes and widths and on epc_ifs for the channel interfaces.

module epc_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    epc_in_if           in_ch,
    epc_out_if          out_ch,
    output int          fail_count,
    output int          pending_results,
    output int          results_checked,
    output logic [10:0] classes_seen
);

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  packet_class;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        truncated;
        logic [31:0] counter_value;
    } result_beat_t;

    // Parser state of the frame in progress
    epc_pkg::pos_t     frame_pos;
    logic [15:0]       frame_etype;
    logic [1:0]        net_kind;
    epc_pkg::pos_t     l4_start;
    logic [7:0]        l3_proto;
    logic [15:0]       src_port_reg;
    logic [15:0]       dst_port_reg;
    epc_pkg::counter_t class_counts [epc_pkg::NUM_COUNTERS];

    result_beat_t awaited_beats[$];
    int           errors;
    int           checked;
    logic [10:0]  seen_mask;

    // Drop the frame in progress
    task automatic clear_frame();
        frame_pos = '0;
        frame_etype = '0;
        net_kind = epc_pkg::NK_NONE;
        l4_start = '0;
        l3_proto = '0;
        src_port_reg = '0;
        dst_port_reg = '0;
    endtask

    // Advance one packet counter, wrapping at its width
    task automatic bump_count(input int idx);
        class_counts[idx] = class_counts[idx] + epc_pkg::counter_t'(1);
    endtask

    // Advance the header parser by one frame byte
    task automatic absorb_byte(input logic [7:0] b);
        int         idx;
        int         off;
        logic [3:0] ihl;
        idx = int'(frame_pos);
        if (idx == epc_pkg::ETYPE_HI_IDX)
            frame_etype = {b, 8'h00};
        if (idx == epc_pkg::ETYPE_LO_IDX)
        begin
            frame_etype[7:0] = b;
            if (frame_etype == epc_pkg::ETYPE_IPV4)
                net_kind = epc_pkg::NK_IP4;
            else if (frame_etype == epc_pkg::ETYPE_IPV6)
            begin
                net_kind = epc_pkg::NK_IP6;
                l4_start = epc_pkg::IP6_L4_START;
            end
            else if (frame_etype == epc_pkg::ETYPE_ARP)
                net_kind = epc_pkg::NK_ARP;
            else
                net_kind = epc_pkg::NK_NONE;
        end
        // Place layer 4 from the IHL nibble, clamping short headers
        if (net_kind == epc_pkg::NK_IP4 && idx == epc_pkg::ETH_HDR_LEN)
        begin
            ihl = (b[3:0] < epc_pkg::IHL_MIN) ? epc_pkg::IHL_MIN : b[3:0];
            l4_start = epc_pkg::pos_t'(int'(epc_pkg::ETH_HDR_LEN) + 4 * int'(ihl));
        end
        if (net_kind == epc_pkg::NK_IP4 && idx == epc_pkg::IP4_PROTO_IDX)
            l3_proto = b;
        if (net_kind == epc_pkg::NK_IP6 && idx == epc_pkg::IP6_NH_IDX)
            l3_proto = b;
        // Capture the port bytes, high byte first
        if ((net_kind == epc_pkg::NK_IP4 || net_kind == epc_pkg::NK_IP6)
            && idx >= epc_pkg::ETH_HDR_LEN && l4_start != '0 && idx >= int'(l4_start)
            && idx < int'(l4_start) + int'(epc_pkg::L4_PORT_BYTES))
        begin
            off = idx - int'(l4_start);
            case (off)
                0: src_port_reg = {b, 8'h00};
                1: src_port_reg[7:0] = b;
                2: dst_port_reg = {b, 8'h00};
                default: dst_port_reg[7:0] = b;
            endcase
        end
        if (frame_pos < epc_pkg::POS_MAX)
            frame_pos = frame_pos + 7'd1;
    endtask

    // Decide the class of the finished frame and bump the counters it reached
    task automatic classify_frame(output result_beat_t r);
        int cnt;
        bit v4;
        bit tcp;
        r = '0;
        r.result_kind = epc_pkg::KIND_FRAME;
        r.packet_class = epc_pkg::CLS_UNKNOWN;
        cnt = int'(frame_pos);
        bump_count(epc_pkg::CNT_TOTAL);
        if (cnt < epc_pkg::ETH_HDR_LEN)
            r.truncated = 1'b1;
        else
        begin
            r.ether_type = frame_etype;
            if (net_kind == epc_pkg::NK_ARP)
            begin
                r.packet_class = epc_pkg::CLS_ARP;
                bump_count(epc_pkg::CNT_ARP);
            end
            else if (net_kind == epc_pkg::NK_NONE)
                bump_count(epc_pkg::CNT_OTHER);
            else
            begin
                v4 = (net_kind == epc_pkg::NK_IP4);
                if (v4)
                    bump_count(epc_pkg::CNT_IPV4);
                else
                    bump_count(epc_pkg::CNT_IPV6);
                if (cnt < int'(v4 ? epc_pkg::IP4_PROTO_END : epc_pkg::IP6_NH_END))
                    r.truncated = 1'b1;
                else
                begin
                    r.ip_protocol = l3_proto;
                    if (v4 && l3_proto == epc_pkg::PROTO_ICMP)
                    begin
                        r.packet_class = epc_pkg::CLS_ICMP;
                        bump_count(epc_pkg::CNT_ICMP);
                    end
                    else if (!v4 && l3_proto == epc_pkg::PROTO_ICMPV6)
                    begin
                        r.packet_class = epc_pkg::CLS_ICMPV6;
                        bump_count(epc_pkg::CNT_ICMPV6);
                    end
                    else if (l3_proto == epc_pkg::PROTO_TCP || l3_proto == epc_pkg::PROTO_UDP)
                    begin
                        tcp = (l3_proto == epc_pkg::PROTO_TCP);
                        if (tcp)
                            bump_count(epc_pkg::CNT_TCP);
                        else
                            bump_count(epc_pkg::CNT_UDP);
                        if (cnt < int'(l4_start) + int'(epc_pkg::L4_PORT_BYTES))
                        begin
                            r.truncated = 1'b1;
                            r.packet_class = tcp ? epc_pkg::CLS_TCP : epc_pkg::CLS_UDP;
                        end
                        else
                        begin
                            r.source_port = src_port_reg;
                            r.dest_port = dst_port_reg;
                            if (tcp)
                            begin
                                if (src_port_reg == epc_pkg::PORT_HTTP
                                    || dst_port_reg == epc_pkg::PORT_HTTP)
                                    r.packet_class = epc_pkg::CLS_HTTP;
                                else if (src_port_reg == epc_pkg::PORT_FTP
                                         || dst_port_reg == epc_pkg::PORT_FTP)
                                    r.packet_class = epc_pkg::CLS_FTP;
                                else if (src_port_reg == epc_pkg::PORT_HTTPS
                                         || dst_port_reg == epc_pkg::PORT_HTTPS)
                                    r.packet_class = epc_pkg::CLS_HTTPS;
                                else
                                    r.packet_class = epc_pkg::CLS_TCP;
                            end
                            else
                            begin
                                if (src_port_reg == epc_pkg::PORT_DNS
                                    || dst_port_reg == epc_pkg::PORT_DNS)
                                    r.packet_class = epc_pkg::CLS_DNS;
                                else if (src_port_reg == epc_pkg::PORT_DHCP
                                         || dst_port_reg == epc_pkg::PORT_DHCP)
                                    r.packet_class = epc_pkg::CLS_DHCP;
                                else
                                    r.packet_class = epc_pkg::CLS_UDP;
                            end
                        end
                    end
                end
            end
        end
        clear_frame();
    endtask

    function automatic int field_differs(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_beat_t r;
        result_beat_t want;
        int           bad;
        if (!rst_n)
        begin
            clear_frame();
            for (int i = 0; i < epc_pkg::NUM_COUNTERS; i++)
                class_counts[i] = '0;
            awaited_beats.delete();
            errors = 0;
            checked = 0;
            seen_mask = '0;
        end
        else
        begin
            // Predict the result of an accepted input beat
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.action == epc_pkg::ACT_READ)
                begin
                    r = '0;
                    r.result_kind = epc_pkg::KIND_COUNT;
                    if (in_ch.counter_select < epc_pkg::NUM_COUNTERS)
                        r.counter_value = 32'(class_counts[in_ch.counter_select]);
                    awaited_beats.push_back(r);
                end
                else
                begin
                    absorb_byte(in_ch.data_byte);
                    if (in_ch.last_byte)
                    begin
                        classify_frame(r);
                        awaited_beats.push_back(r);
                    end
                end
            end
            // Compare an accepted result beat with the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                checked++;
                if (out_ch.result_kind == epc_pkg::KIND_FRAME
                    && out_ch.packet_class <= epc_pkg::CLS_UDP)
                    seen_mask[out_ch.packet_class] = 1'b1;
                if (awaited_beats.size() == 0)
                begin
                    $error("result beat with no prediction waiting (kind %0d)",
                           out_ch.result_kind);
                    errors++;
                end
                else
                begin
                    want = awaited_beats.pop_front();
                    bad = 0;
                    bad += field_differs("result_kind", 32'(want.result_kind),
                                         32'(out_ch.result_kind));
                    bad += field_differs("packet_class", 32'(want.packet_class),
                                         32'(out_ch.packet_class));
                    bad += field_differs("ether_type", 32'(want.ether_type),
                                         32'(out_ch.ether_type));
                    bad += field_differs("ip_protocol", 32'(want.ip_protocol),
                                         32'(out_ch.ip_protocol));
                    bad += field_differs("source_port", 32'(want.source_port),
                                         32'(out_ch.source_port));
                    bad += field_differs("dest_port", 32'(want.dest_port),
                                         32'(out_ch.dest_port));
                    bad += field_differs("truncated", 32'(want.truncated),
                                         32'(out_ch.truncated));
                    bad += field_differs("counter_value", want.counter_value,
                                         out_ch.counter_value);
                    if (bad != 0)
                        errors++;
                end
            end
        end
        fail_count <= errors;
        pending_results <= awaited_beats.size();
        results_checked <= checked;
        classes_seen <= seen_mask;
    end

endmodule

>>> verif/ethernet_packet_classifier_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the Ethernet packet classifier: clock, reset, stimulus and verdict.
// Depends on epc_pkg, epc_ifs, the classifier RTL and epc_frame_checker.

module ethernet_packet_classifier_top_tb;

    localparam int HALF_PERIOD        = 6;
    localparam int RESET_CYCLES       = 10;
    localparam int TOTAL_BEATS        = 950;
    localparam int READBACK_SELECTS   = 16;
    localparam int HOLD_AFTER_RESULTS = 20;
    localparam int HOLD_CYCLES        = 300;
    localparam int STALL_LIMIT        = 5000;
    localparam int DRAIN_CYCLES       = 20;
    localparam int FRAME_BUF_LEN      = 160;
    localparam int LONG_FRAME_LEN     = 130;
    localparam int PLAIN_FRAME_LEN    = 22;

    logic clk = 1'b0;
    logic rst_n;

    epc_in_if  in_ch();
    epc_out_if out_ch();

    int          fail_count;
    int          pending_results;
    int          results_checked;
    logic [10:0] classes_seen;

    ethernet_packet_classifier_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    epc_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .classes_seen    (classes_seen)
    );

    always #(HALF_PERIOD) clk = ~clk;

    int         send_idle_pct;
    int         recv_idle_pct;
    int         beats_sent;
    int         frames_sent;
    int         reads_sent;
    int         results_issued;
    logic [7:0] frame_bytes [FRAME_BUF_LEN];
    int         frame_len;

    // Offer one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic drive_beat(input logic act, input logic [7:0] b, input logic last,
                              input logic [3:0] sel);
        // Pick the idling mix for the current third of the run
        if (beats_sent < TOTAL_BEATS / 3)
        begin
            send_idle_pct = 17;
            recv_idle_pct = 54;
        end
        else if (beats_sent < 2 * TOTAL_BEATS / 3)
        begin
            send_idle_pct = 54;
            recv_idle_pct = 17;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        in_ch.counter_select <= sel;
        do
            @(posedge clk);
        while (!in_ch.ready);
        beats_sent++;
    endtask

    task automatic send_count_read(input logic [3:0] sel);
        drive_beat(epc_pkg::ACT_READ, 8'($urandom), 1'($urandom), sel);
        reads_sent++;
        results_issued++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_len; i++)
            drive_beat(epc_pkg::ACT_DATA, frame_bytes[i], i == frame_len - 1, 4'($urandom));
        frames_sent++;
        results_issued++;
    endtask

    // Fill the frame buffer with random bytes, then lay the headers over them
    task automatic build_frame(input logic [15:0] etype, input logic [7:0] proto,
                               input logic [3:0] ihl, input logic [15:0] sport,
                               input logic [15:0] dport);
        int l4;
        for (int i = 0; i < FRAME_BUF_LEN; i++)
            frame_bytes[i] = 8'($urandom);
        frame_bytes[epc_pkg::ETYPE_HI_IDX] = etype[15:8];
        frame_bytes[epc_pkg::ETYPE_LO_IDX] = etype[7:0];
        l4 = 0;
        if (etype == epc_pkg::ETYPE_IPV4)
        begin
            frame_bytes[epc_pkg::ETH_HDR_LEN] = {4'h4, ihl};
            frame_bytes[epc_pkg::IP4_PROTO_IDX] = proto;
            l4 = int'(epc_pkg::ETH_HDR_LEN)
                 + 4 * int'((ihl < epc_pkg::IHL_MIN) ? epc_pkg::IHL_MIN : ihl);
        end
        else if (etype == epc_pkg::ETYPE_IPV6)
        begin
            frame_bytes[epc_pkg::IP6_NH_IDX] = proto;
            l4 = int'(epc_pkg::IP6_L4_START);
        end
        if (l4 != 0)
        begin
            frame_bytes[l4]     = sport[15:8];
            frame_bytes[l4 + 1] = sport[7:0];
            frame_bytes[l4 + 2] = dport[15:8];
            frame_bytes[l4 + 3] = dport[7:0];
            frame_len = l4 + int'(epc_pkg::L4_PORT_BYTES);
        end
        else
            frame_len = PLAIN_FRAME_LEN;
    endtask

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 9))
            0: return epc_pkg::PORT_HTTP;
            1: return epc_pkg::PORT_FTP;
            2: return epc_pkg::PORT_HTTPS;
            3: return epc_pkg::PORT_DNS;
            4: return epc_pkg::PORT_DHCP;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        int          pick;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        pick = int'($urandom_range(99));
        if (pick < 8)
            etype = epc_pkg::ETYPE_ARP;
        else if (pick < 16)
            etype = 16'($urandom);
        else if (pick < 60)
            etype = epc_pkg::ETYPE_IPV4;
        else
            etype = epc_pkg::ETYPE_IPV6;
        pick = int'($urandom_range(99));
        if (pick < 15)
            proto = (etype == epc_pkg::ETYPE_IPV6) ? epc_pkg::PROTO_ICMPV6 : epc_pkg::PROTO_ICMP;
        else if (pick < 50)
            proto = epc_pkg::PROTO_TCP;
        else if (pick < 85)
            proto = epc_pkg::PROTO_UDP;
        else
            proto = 8'($urandom);
        ihl = ($urandom_range(99) < 70) ? epc_pkg::IHL_MIN : 4'($urandom);
        build_frame(etype, proto, ihl, pick_port(), pick_port());
        // Cut short, run long past the parser window, or pad a little
        pick = int'($urandom_range(99));
        if (pick < 8)
            frame_len = int'($urandom_range(1, frame_len - 1));
        else if (pick < 11)
            frame_len = int'($urandom_range(128, 136));
        else
            frame_len += int'($urandom_range(0, 6));
        send_frame();
    endtask

    task automatic run_directed();
        send_count_read(4'(epc_pkg::CNT_TOTAL));
        build_frame(epc_pkg::ETYPE_ARP, 8'h00, epc_pkg::IHL_MIN, 16'h0000, 16'h0000);
        send_frame();
        build_frame(16'h0000, 8'h00, epc_pkg::IHL_MIN, 16'h0000, 16'h0000);
        send_frame();
        build_frame(16'hFFFF, 8'h00, epc_pkg::IHL_MIN, 16'h0000, 16'h0000);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_ICMP, epc_pkg::IHL_MIN,
                    16'h0000, 16'h0000);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV6, epc_pkg::PROTO_ICMPV6, epc_pkg::IHL_MIN,
                    16'h0000, 16'h0000);
        send_frame();
        // Each well-known port, on either side, and the port priority order
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_TCP, epc_pkg::IHL_MIN,
                    epc_pkg::PORT_HTTP, 16'hFFFF);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV6, epc_pkg::PROTO_TCP, epc_pkg::IHL_MIN,
                    16'h0000, epc_pkg::PORT_FTP);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_TCP, 4'hF,
                    epc_pkg::PORT_HTTPS, epc_pkg::PORT_HTTP);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_TCP, 4'h6,
                    16'h1000, epc_pkg::PORT_HTTPS);
        send_frame();
        // IHL of zero is clamped to the minimum header
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_UDP, 4'h0, 16'h8001, epc_pkg::PORT_DNS);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV6, epc_pkg::PROTO_UDP, epc_pkg::IHL_MIN,
                    epc_pkg::PORT_DHCP, epc_pkg::PORT_DNS);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV6, epc_pkg::PROTO_UDP, epc_pkg::IHL_MIN,
                    epc_pkg::PORT_DHCP, 16'h7FFF);
        send_frame();
        // ICMP codes under the wrong IP version are unlisted protocols
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_ICMPV6, epc_pkg::IHL_MIN,
                    16'h0000, 16'h0000);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV6, epc_pkg::PROTO_ICMP, epc_pkg::IHL_MIN,
                    16'h0000, 16'h0000);
        send_frame();
        // Frames ending early at each layer
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_TCP, epc_pkg::IHL_MIN,
                    epc_pkg::PORT_HTTP, epc_pkg::PORT_HTTP);
        frame_len = 1;
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_TCP, epc_pkg::IHL_MIN,
                    epc_pkg::PORT_HTTP, epc_pkg::PORT_HTTP);
        frame_len = int'(epc_pkg::ETYPE_LO_IDX);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_TCP, epc_pkg::IHL_MIN,
                    epc_pkg::PORT_HTTP, epc_pkg::PORT_HTTP);
        frame_len = int'(epc_pkg::ETH_HDR_LEN);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV6, epc_pkg::PROTO_UDP, epc_pkg::IHL_MIN,
                    epc_pkg::PORT_DNS, epc_pkg::PORT_DNS);
        frame_len = int'(epc_pkg::IP6_NH_IDX);
        send_frame();
        build_frame(epc_pkg::ETYPE_IPV4, epc_pkg::PROTO_TCP, epc_pkg::IHL_MIN,
                    epc_pkg::PORT_HTTP, epc_pkg::PORT_HTTP);
        frame_len = frame_len - 2;
        send_frame();
        // Frame running past the last parsed byte
        build_frame(epc_pkg::ETYPE_IPV6, epc_pkg::PROTO_UDP, epc_pkg::IHL_MIN,
                    16'h1111, epc_pkg::PORT_DNS);
        frame_len = LONG_FRAME_LEN;
        send_frame();
        send_count_read(4'(epc_pkg::CNT_OTHER));
        send_count_read(4'd9);
        send_count_read(4'hF);
    endtask

    // Receiver: one long hold-off once traffic is flowing, random stalls otherwise
    initial
    begin : receiver
        int  results_taken;
        bit  hold_done;
        results_taken = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && results_taken >= HOLD_AFTER_RESULTS)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge clk);
                if (out_ch.valid && out_ch.ready)
                    results_taken++;
            end
        end
    end

    // Watchdog: end the run once no beat has moved for too long
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        send_idle_pct = 17;
        recv_idle_pct = 54;
        beats_sent = 0;
        frames_sent = 0;
        reads_sent = 0;
        results_issued = 0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.action <= epc_pkg::ACT_DATA;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        in_ch.counter_select <= 4'h0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random traffic until the beat budget is spent
        while (beats_sent < TOTAL_BEATS - READBACK_SELECTS)
        begin
            if ($urandom_range(99) < 25)
                send_count_read(($urandom_range(99) < 85) ? 4'($urandom_range(0, 8))
                                                          : 4'($urandom_range(9, 15)));
            else
                send_random_frame();
        end

        // Read back every counter select, valid or not
        for (int s = 0; s < READBACK_SELECTS; s++)
            send_count_read(4'(s));
        in_ch.valid <= 1'b0;

        // Drain the outstanding results
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d beats: %0d frames and %0d counter reads, %0d results compared",
                 beats_sent, frames_sent, reads_sent, results_checked);
        $display("Frame classes seen (UDP..unknown): %b", classes_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> ethernet_packet_classifier_top.f
src/epc_pkg.sv
src/epc_ifs.sv
src/ethernet_packet_classifier_top.sv
verif/epc_frame_checker.sv
verif/ethernet_packet_classifier_top_tb.sv
